[rtl/pwm_pdm_tick_generator_macros.svh]
// assertion helpers shared by the tick generator modules
`ifndef PWM_PDM_TICK_GENERATOR_MACROS_SVH
`define PWM_PDM_TICK_GENERATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define PTG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ptg_pkg.sv]
package ptg_pkg;

    localparam int TIMER_WIDTH_DEF = 32;

    localparam int TICK_W      = 30;
    localparam int LEN_W       = 31;
    localparam int MODE_W      = 2;
    localparam int STYLE_W     = 2;
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_INDEX_W = 3;

    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PWM    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DITHER = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PDM    = 2'd3;

    localparam logic [STYLE_W-1:0] STYLE_SINGLE = 2'd0;
    localparam logic [STYLE_W-1:0] STYLE_DIR    = 2'd1;
    localparam logic [STYLE_W-1:0] STYLE_UPDOWN = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REVERSE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_USE_MEAS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_NOMINAL = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_STYLE   = 3'd6;

    localparam logic [LEN_W-1:0]  RST_PERIOD  = 31'd50000;
    localparam logic [TICK_W-1:0] RST_NOMINAL = 30'd50000;

    typedef struct packed {
        logic [MODE_W-1:0]  modulation_mode;
        logic [LEN_W-1:0]   period_length;
        logic [LEN_W-1:0]   high_length;
        logic               reverse_direction;
        logic               use_measured_tick;
        logic [TICK_W-1:0]  nominal_tick;
        logic [STYLE_W-1:0] output_style;
    } ptg_cfg_t;

    typedef struct packed {
        logic drive;
        logic down;
        logic dir;
    } ptg_result_t;

endpackage

[rtl/ptg_cfg.sv]
module ptg_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ptg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ptg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ptg_pkg::ptg_cfg_t             cfg
);
    import ptg_pkg::*;

    ptg_cfg_t cfg_reg;
    ptg_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:     cfg_next.modulation_mode   = cfg_data[MODE_W-1:0];
                REG_PERIOD:   cfg_next.period_length     = cfg_data[LEN_W-1:0];
                REG_HIGH:     cfg_next.high_length       = cfg_data[LEN_W-1:0];
                REG_REVERSE:  cfg_next.reverse_direction = cfg_data[0];
                REG_USE_MEAS: cfg_next.use_measured_tick = cfg_data[0];
                REG_NOMINAL:  cfg_next.nominal_tick      = cfg_data[TICK_W-1:0];
                REG_STYLE:    cfg_next.output_style      = cfg_data[STYLE_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modulation_mode   <= MODE_OFF;
            cfg_reg.period_length     <= RST_PERIOD;
            cfg_reg.high_length       <= '0;
            cfg_reg.reverse_direction <= 1'b0;
            cfg_reg.use_measured_tick <= 1'b0;
            cfg_reg.nominal_tick      <= RST_NOMINAL;
            cfg_reg.output_style      <= STYLE_SINGLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/ptg_core.sv]
`include "pwm_pdm_tick_generator_macros.svh"

module ptg_core #(
    parameter int TIMER_WIDTH = ptg_pkg::TIMER_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [ptg_pkg::TICK_W-1:0] tick,
    input  ptg_pkg::ptg_cfg_t        cfg,
    output ptg_pkg::ptg_result_t     result
);
    import ptg_pkg::*;

    // compare width: sign-extended counter against zero-extended 31-bit length
    localparam int CW = ((TIMER_WIDTH > LEN_W) ? TIMER_WIDTH : LEN_W) + 2;

    logic [TIMER_WIDTH-1:0] period_reg;
    logic [TIMER_WIDTH-1:0] period_next;
    logic [TIMER_WIDTH-1:0] acc_reg;
    logic [TIMER_WIDTH-1:0] acc_next;
    logic                   level_reg;
    logic                   level_next;

    logic [TICK_W-1:0]      dt_raw;
    logic [CW-1:0]          dt_x;
    logic [CW-1:0]          hl_x;
    logic [CW-1:0]          pl_x;
    logic [TIMER_WIDTH-1:0] dt_t;
    logic [TIMER_WIDTH-1:0] hl_t;
    logic [TIMER_WIDTH-1:0] pl_t;
    logic signed [CW-1:0]   hl_s;
    logic signed [CW-1:0]   pl_s;

    logic [TIMER_WIDTH-1:0] per_add;
    logic                   per_wrap;
    logic [TIMER_WIDTH-1:0] acc_add;
    logic [TIMER_WIDTH-1:0] acc_sub;
    logic [TIMER_WIDTH-1:0] acc_mid;
    logic                   lev_mid;
    logic [TIMER_WIDTH-1:0] acc_carry;
    logic [TIMER_WIDTH-1:0] acc_pdm;

    function automatic logic signed [CW-1:0] sext(input logic [TIMER_WIDTH-1:0] x);
        return {{(CW-TIMER_WIDTH){x[TIMER_WIDTH-1]}}, x};
    endfunction

    function automatic logic is_pos(input logic [TIMER_WIDTH-1:0] x);
        return !x[TIMER_WIDTH-1] && (x != '0);
    endfunction

    always_comb
    begin
        dt_raw = cfg.use_measured_tick ? tick : cfg.nominal_tick;
        dt_x   = CW'(dt_raw);
        hl_x   = CW'(cfg.high_length);
        pl_x   = CW'(cfg.period_length);
        dt_t   = dt_x[TIMER_WIDTH-1:0];
        hl_t   = hl_x[TIMER_WIDTH-1:0];
        pl_t   = pl_x[TIMER_WIDTH-1:0];
        hl_s   = hl_x;
        pl_s   = pl_x;

        per_add  = period_reg + dt_t;
        per_wrap = sext(per_add) >= pl_s;
        acc_add  = acc_reg + dt_t;
        acc_sub  = acc_reg - dt_t;

        // dithered pwm: drain while high, then refill at the period edge
        acc_mid   = level_reg ? acc_sub : acc_reg;
        lev_mid   = level_reg && is_pos(acc_sub);
        acc_carry = acc_mid + hl_t;

        acc_pdm = acc_reg + hl_t - (level_reg ? dt_t : '0);

        period_next = period_reg;
        acc_next    = acc_reg;
        level_next  = level_reg;

        case (cfg.modulation_mode)
            MODE_PWM:
            begin
                if (level_reg)
                begin
                    acc_next = acc_add;
                    if (sext(acc_add) >= hl_s)
                    begin
                        level_next = 1'b0;
                    end
                end
                period_next = per_add;
                if (per_wrap)
                begin
                    period_next = '0;
                    acc_next    = '0;
                    if (cfg.high_length != '0)
                    begin
                        level_next = 1'b1;
                    end
                end
            end
            MODE_DITHER:
            begin
                acc_next    = acc_mid;
                level_next  = lev_mid;
                period_next = per_add;
                if (per_wrap)
                begin
                    period_next = per_add - pl_t;
                    acc_next    = acc_carry;
                    level_next  = lev_mid || is_pos(acc_carry);
                end
            end
            MODE_PDM:
            begin
                acc_next   = acc_pdm;
                level_next = is_pos(acc_pdm);
            end
            default:
            begin
                period_next = '0;
                acc_next    = '0;
                level_next  = 1'b0;
            end
        endcase

        // output styles above single/dir behave as up/down lines
        if (cfg.output_style == STYLE_SINGLE || cfg.output_style == STYLE_DIR)
        begin
            result.drive = level_next;
            result.down  = 1'b0;
            result.dir   = (cfg.output_style == STYLE_DIR) && cfg.reverse_direction;
        end
        else
        begin
            result.drive = level_next && !cfg.reverse_direction;
            result.down  = level_next && cfg.reverse_direction;
            result.dir   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            acc_reg    <= '0;
            level_reg  <= 1'b0;
        end
        else if (step)
        begin
            period_reg <= period_next;
            acc_reg    <= acc_next;
            level_reg  <= level_next;
        end
    end

    `PTG_ASSERT_NEXT(a_disabled_clears, step && (cfg.modulation_mode == MODE_OFF),
        (period_reg == '0) && (acc_reg == '0) && !level_reg, "disabled tick left state set")
    `PTG_ASSERT_NEXT(a_idle_holds, !step,
        $stable(level_reg) && $stable(acc_reg) && $stable(period_reg),
        "state changed without a tick")
    `PTG_ASSERT_NEXT(a_pure_restart, step && (cfg.modulation_mode == MODE_PWM) && per_wrap,
        period_reg == '0, "pure pwm period did not restart")

endmodule

[rtl/pwm_pdm_tick_generator.sv]
// Tick-driven PWM/PDM generator: each input transaction is one base tick carrying
// its measured length, and yields exactly one output transaction with the line
// levels after that tick. One tick is accepted every clock cycle while in_stall is low; a result
// is offered once its tick has passed the input register and then the update of period
// counter, high-time accumulator and level into the result register.
// The user must write configuration registers through the plain write port while no tick
// is in flight (not enforced by the block); an index beyond the register list is ignored.
`include "pwm_pdm_tick_generator_macros.svh"

module pwm_pdm_tick_generator #(
    parameter int TIMER_WIDTH = ptg_pkg::TIMER_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ptg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ptg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ptg_pkg::TICK_W-1:0]      measured_tick,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            drive_out,
    output logic                            down_out,
    output logic                            dir_out
);
    import ptg_pkg::*;

    ptg_cfg_t          cfg;
    ptg_result_t       core_result;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [TICK_W-1:0] s1_tick_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    ptg_result_t       result_reg;

    logic              advance;
    logic              accept;

    ptg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ptg_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .tick   (s1_tick_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // the held tick moves on whenever the result register is free or being drained
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_tick_reg <= measured_tick;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive_out = result_reg.drive;
    assign down_out  = result_reg.down;
    assign dir_out   = result_reg.dir;

    `PTG_ASSERT_NOW(a_stall_has_item, in_stall, s1_valid_reg && out_valid_reg,
        "stall without a blocked tick")
    `PTG_ASSERT_NEXT(a_advance_shows, advance, out_valid_reg,
        "tick advanced but no result shown")
    `PTG_ASSERT_NOW(a_blocked_stalls, s1_valid_reg && out_valid_reg && out_stall, in_stall,
        "input taken while pipeline blocked")

endmodule

[verif/ptg_line_check.sv]
module ptg_line_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ptg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ptg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [ptg_pkg::TICK_W-1:0]      measured_tick,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            drive_out,
    input  logic                            down_out,
    input  logic                            dir_out,
    output int                              fail_count,
    output int                              pending,
    output int                              checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import ptg_pkg::*;

    localparam int TW = TIMER_WIDTH_DEF;

    ptg_cfg_t       regs;
    logic [TW-1:0]  period_count;
    logic [TW-1:0]  high_acc;
    logic           level;
    ptg_result_t    line_levels_q[$];

    function automatic longint sx(input logic [TW-1:0] v);
        return longint'($signed(v));
    endfunction

    // advances the generator by one tick and returns the line levels after it
    function automatic ptg_result_t advance_tick(input logic [TICK_W-1:0] meas);
        logic [TW-1:0] dt;
        longint        hl;
        longint        pl;
        ptg_result_t   r;
        dt = regs.use_measured_tick ? TW'(meas) : TW'(regs.nominal_tick);
        hl = longint'(regs.high_length);
        pl = longint'(regs.period_length);
        case (regs.modulation_mode)
            MODE_PWM:
            begin
                if (level)
                begin
                    high_acc = high_acc + dt;
                    if (sx(high_acc) >= hl)
                        level = 1'b0;
                end
                period_count = period_count + dt;
                if (sx(period_count) >= pl)
                begin
                    period_count = '0;
                    high_acc = '0;
                    if (hl > 0)
                        level = 1'b1;
                end
            end
            MODE_DITHER:
            begin
                if (level)
                begin
                    high_acc = high_acc - dt;
                    if (sx(high_acc) <= 0)
                        level = 1'b0;
                end
                period_count = period_count + dt;
                if (sx(period_count) >= pl)
                begin
                    // keep the overshoot of both counters for the next period
                    period_count = period_count - TW'(regs.period_length);
                    high_acc = high_acc + TW'(regs.high_length);
                    if (sx(high_acc) > 0)
                        level = 1'b1;
                end
            end
            MODE_PDM:
            begin
                high_acc = high_acc + TW'(regs.high_length);
                if (level)
                    high_acc = high_acc - dt;
                level = sx(high_acc) > 0;
            end
            default:
            begin
                level = 1'b0;
                high_acc = '0;
                period_count = '0;
            end
        endcase
        if (regs.output_style == STYLE_SINGLE || regs.output_style == STYLE_DIR)
        begin
            r.drive = level;
            r.down  = 1'b0;
            r.dir   = (regs.output_style == STYLE_DIR) ? regs.reverse_direction : 1'b0;
        end
        else
        begin
            // up/down lines, also for the unused style code
            r.drive = level & ~regs.reverse_direction;
            r.down  = level & regs.reverse_direction;
            r.dir   = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ptg_result_t e;
        if (!rst_n)
        begin
            regs = '{modulation_mode: MODE_OFF, period_length: RST_PERIOD,
                     high_length: '0, reverse_direction: 1'b0, use_measured_tick: 1'b0,
                     nominal_tick: RST_NOMINAL, output_style: STYLE_SINGLE};
            period_count = '0;
            high_acc = '0;
            level = 1'b0;
            line_levels_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                line_levels_q.push_back(advance_tick(measured_tick));
            if (out_valid && !out_stall)
            begin
                checked++;
                if (line_levels_q.size() == 0)
                    report_mismatch("output transaction with no tick outstanding");
                else
                begin
                    e = line_levels_q.pop_front();
                    if (drive_out !== e.drive)
                        report_mismatch($sformatf("drive_out got %b expected %b",
                                                  drive_out, e.drive));
                    if (down_out !== e.down)
                        report_mismatch($sformatf("down_out got %b expected %b",
                                                  down_out, e.down));
                    if (dir_out !== e.dir)
                        report_mismatch($sformatf("dir_out got %b expected %b",
                                                  dir_out, e.dir));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:     regs.modulation_mode   = cfg_data[MODE_W-1:0];
                    REG_PERIOD:   regs.period_length     = cfg_data[LEN_W-1:0];
                    REG_HIGH:     regs.high_length       = cfg_data[LEN_W-1:0];
                    REG_REVERSE:  regs.reverse_direction = cfg_data[0];
                    REG_USE_MEAS: regs.use_measured_tick = cfg_data[0];
                    REG_NOMINAL:  regs.nominal_tick      = cfg_data[TICK_W-1:0];
                    REG_STYLE:    regs.output_style      = cfg_data[STYLE_W-1:0];
                    default:      ;
                endcase
            end
        end
        pending = line_levels_q.size();
    end

endmodule

[verif/tb_pwm_pdm_tick_generator.sv]
module tb_pwm_pdm_tick_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import ptg_pkg::*;

    localparam int RANDOM_TICKS = 700;
    localparam int QUIET_TICKS  = 60;
    localparam int LONG_HOLD    = 200;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED  = 3'd7;
    localparam logic [STYLE_W-1:0]     STYLE_SPARE = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic [TICK_W-1:0]      measured_tick = '0;
    logic                   out_stall = 1'b0;
    logic                   in_stall;
    logic                   out_valid;
    logic                   drive_out;
    logic                   down_out;
    logic                   dir_out;

    int fail_count;
    int pending;
    int checked;
    int ticks_sent;
    int settings_used;
    int rx_hold_left;
    bit tx_bursts;
    bit rx_bursts;
    bit long_hold_req;

    pwm_pdm_tick_generator dut (.*);

    ptg_line_check line_check (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d output transactions outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

    // receiver side: random stall bursts and one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_left == 0)
            begin
                if (long_hold_req)
                begin
                    long_hold_req = 1'b0;
                    rx_hold_left = LONG_HOLD;
                end
                else if (rx_bursts && $urandom_range(0, 9) == 0)
                    rx_hold_left = $urandom_range(1, 15);
            end
            if (rx_hold_left != 0)
            begin
                out_stall <= 1'b1;
                rx_hold_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_tick(input logic [TICK_W-1:0] t);
        if (tx_bursts && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        measured_tick <= t;
        do
            @(posedge clk);
        while (in_stall);
        ticks_sent++;
    endtask

    // stop offering ticks and let every outstanding result come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
    endtask

    task automatic apply_settings(input ptg_cfg_t c);
        drain();
        put_reg(REG_MODE, CFG_DATA_W'(c.modulation_mode));
        put_reg(REG_PERIOD, CFG_DATA_W'(c.period_length));
        put_reg(REG_HIGH, CFG_DATA_W'(c.high_length));
        put_reg(REG_REVERSE, CFG_DATA_W'(c.reverse_direction));
        put_reg(REG_USE_MEAS, CFG_DATA_W'(c.use_measured_tick));
        put_reg(REG_NOMINAL, CFG_DATA_W'(c.nominal_tick));
        put_reg(REG_STYLE, CFG_DATA_W'(c.output_style));
        // an index past the register list must not disturb anything
        put_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        ptg_cfg_t          c;
        logic [TICK_W-1:0] t;
        int                run_len;
        int                directed_ticks;
        bit                held_once;

        held_once = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: generator disabled
        send_tick('0);
        send_tick('1);

        // pure pwm, zero period, full high time, minimal nominal tick
        c = '{modulation_mode: MODE_PWM, period_length: '0, high_length: '1,
              reverse_direction: 1'b1, use_measured_tick: 1'b1, nominal_tick: 30'd1,
              output_style: STYLE_DIR};
        apply_settings(c);
        send_tick('0);
        send_tick(30'd1_000_000_000);
        send_tick('1);
        send_tick(30'd7);

        // period counter wraps past the sign bit before the period ends
        c = '{modulation_mode: MODE_PWM, period_length: '1, high_length: 31'h4000_0000,
              reverse_direction: 1'b0, use_measured_tick: 1'b0, nominal_tick: '1,
              output_style: STYLE_SINGLE};
        apply_settings(c);
        repeat (4) send_tick(TICK_W'($urandom));

        c = '{modulation_mode: MODE_DITHER, period_length: '1, high_length: '1,
              reverse_direction: 1'b1, use_measured_tick: 1'b1,
              nominal_tick: 30'd1_000_000_000, output_style: STYLE_UPDOWN};
        apply_settings(c);
        repeat (4) send_tick('1);

        c = '{modulation_mode: MODE_DITHER, period_length: 31'd3000, high_length: 31'd1000,
              reverse_direction: 1'b0, use_measured_tick: 1'b0, nominal_tick: 30'd1000,
              output_style: STYLE_UPDOWN};
        apply_settings(c);
        repeat (5) send_tick(TICK_W'($urandom));

        // pdm with a zero nominal tick and a wrapping accumulator, spare style code
        c = '{modulation_mode: MODE_PDM, period_length: '0, high_length: '1,
              reverse_direction: 1'b1, use_measured_tick: 1'b0, nominal_tick: '0,
              output_style: STYLE_SPARE};
        apply_settings(c);
        repeat (3) send_tick(TICK_W'($urandom));

        c = '{modulation_mode: MODE_PDM, period_length: 31'd50000, high_length: 31'd300,
              reverse_direction: 1'b0, use_measured_tick: 1'b0, nominal_tick: 30'd1000,
              output_style: STYLE_DIR};
        apply_settings(c);
        repeat (3) send_tick(TICK_W'($urandom));

        directed_ticks = ticks_sent;

        while (ticks_sent < directed_ticks + RANDOM_TICKS)
        begin
            c.modulation_mode = ($urandom_range(0, 9) == 0) ? MODE_OFF
                                                            : MODE_W'($urandom_range(1, 3));
            c.output_style = STYLE_W'($urandom_range(0, 3));
            c.reverse_direction = 1'($urandom_range(0, 1));
            c.use_measured_tick = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 11) == 0)
            begin
                c.nominal_tick = TICK_W'($urandom);
                c.period_length = LEN_W'($urandom);
                c.high_length = LEN_W'($urandom);
            end
            else
            begin
                // up to 40 ticks per period so that edges fall often
                c.nominal_tick = TICK_W'($urandom_range(100, 5000));
                c.period_length = LEN_W'(c.nominal_tick * $urandom_range(1, 40));
                if (c.modulation_mode == MODE_PDM)
                    c.high_length = LEN_W'($urandom_range(0, c.nominal_tick));
                else
                    c.high_length = LEN_W'($urandom_range(0, c.period_length +
                                                             c.nominal_tick));
            end
            apply_settings(c);
            tx_bursts = $urandom_range(0, 3) != 0;
            rx_bursts = $urandom_range(0, 3) != 0;
            if (!held_once)
            begin
                // receiver holds off while ticks keep coming, block fills and stalls
                held_once = 1'b1;
                long_hold_req = 1'b1;
            end
            run_len = $urandom_range(20, 60);
            for (int k = 0; k < run_len; k++)
            begin
                if (ticks_sent >= directed_ticks + RANDOM_TICKS - QUIET_TICKS)
                begin
                    tx_bursts = 1'b0;
                    rx_bursts = 1'b0;
                end
                if (c.use_measured_tick && $urandom_range(0, 15) != 0)
                    t = TICK_W'($urandom_range(c.nominal_tick - c.nominal_tick / 4,
                                               c.nominal_tick + c.nominal_tick / 4));
                else
                    t = TICK_W'($urandom);
                send_tick(t);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (10) @(posedge clk);

        $display("run covered %0d ticks under %0d register settings, all modes and styles",
                 ticks_sent, settings_used);
        $display("%0d output transactions compared, with stall bursts and a long hold-off",
                 checked);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/ptg_pkg.sv
rtl/ptg_cfg.sv
rtl/ptg_core.sv
rtl/pwm_pdm_tick_generator.sv
verif/ptg_line_check.sv
verif/tb_pwm_pdm_tick_generator.sv
